// File: hdl/sqlu_pkg.sv
// ----------------------------------------------------------------------------
// sqlu_pkg
// shared types and constants for the string literal unescape block
// ----------------------------------------------------------------------------
package sqlu_pkg;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_SEVEN  = 8'h37;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CODE_BS   = 8'h08;
  localparam logic [7:0] CODE_FF   = 8'h0C;
  localparam logic [7:0] CODE_LF   = 8'h0A;
  localparam logic [7:0] CODE_CR   = 8'h0D;
  localparam logic [7:0] CODE_TAB  = 8'h09;
  localparam logic [1:0] OCT_MAX_DIGITS = 2'd3;

  typedef enum logic [1:0] {
    MODE_NORMAL,
    MODE_QUOTE,
    MODE_BSLASH,
    MODE_OCTAL
  } mode_t;

  typedef struct packed {
    mode_t      mode;
    logic [7:0] acc;
    logic [1:0] dig;
  } scan_t;

  typedef struct packed {
    logic [7:0] data;
    logic       has;
    logic       last;
  } res_t;

  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } push_t;

  typedef struct packed {
    logic              valid;
    logic              room;
    logic [QCNT_W-1:0] count;
  } qstat_t;

  localparam scan_t SCAN_RESET = '{mode: MODE_NORMAL, acc: 8'h00, dig: 2'd0};

endpackage

// File: hdl/sql_string_unescape.sv
// ----------------------------------------------------------------------------
// sql_string_unescape
// streaming decoder for quoted string bodies with backslash and octal escapes
// ----------------------------------------------------------------------------
// path: an accepted input word is held in the input register, decoded, and
//   written into the result queue, whose head drives the output
// throughput: one input word per cycle while the queue has room; an item
//   yields zero to two words, drained one per cycle from a four-entry queue
// the input stage stalls only while the queue cannot take two more words
// reset: synchronous, active high; clears scan state, input stage and queue
// ----------------------------------------------------------------------------
module sql_string_unescape (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       has_byte,
  output logic       out_last
);
  import sqlu_pkg::*;

  // input register stage
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_last;

  // scan state: mode, octal accumulator, octal digit count
  scan_t  st;
  scan_t  st_next;
  push_t  dec_push;
  push_t  q_push;
  res_t   head;
  qstat_t qstat;
  logic   advance;

  // stage 1 hands its word to the decoder when the queue has room for two
  assign advance  = s1_valid && qstat.room;
  assign in_ready = !s1_valid || qstat.room;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  // payload holds while stalled, no reset needed
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte <= in_byte;
      s1_last <= in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= SCAN_RESET;
    end else if (advance) begin
      st <= st_next;
    end
  end

  sqlu_decode u_decode (
    .st      (st),
    .byte_in (s1_byte),
    .last    (s1_last),
    .st_next (st_next),
    .push    (dec_push)
  );

  // results enter the queue only for a word that actually advances
  always_comb begin
    q_push = dec_push;
    if (!advance) begin
      q_push.n = 2'd0;
    end
  end

  sqlu_outq u_outq (
    .clk  (clk),
    .rst  (rst),
    .push (q_push),
    .pop  (out_ready),
    .head (head),
    .stat (qstat)
  );

  assign out_valid = qstat.valid;
  assign out_byte  = head.data;
  assign has_byte  = head.has;
  assign out_last  = head.last;

  // queue never overfills
  a_q_bound: assert property (@(posedge clk) disable iff (rst)
    qstat.count <= QCNT_W'(QDEPTH))
    else $error("result queue overflow");

  // a final word always produces at least one result
  a_last_result: assert property (@(posedge clk) disable iff (rst)
    (advance && s1_last) |-> (dec_push.n != 2'd0))
    else $error("end of string gave no result");

  // scan state returns to reset after the end of a string
  a_last_reset: assert property (@(posedge clk) disable iff (rst)
    (advance && s1_last) |=> (st.mode == MODE_NORMAL && st.dig == 2'd0))
    else $error("scan state not cleared after end of string");

  // an open octal run holds one or two digits
  a_oct_digits: assert property (@(posedge clk) disable iff (rst)
    (st.mode == MODE_OCTAL) |-> (st.dig == 2'd1 || st.dig == 2'd2))
    else $error("bad octal digit count");

endmodule

// File: hdl/sqlu_decode.sv
// ----------------------------------------------------------------------------
// sqlu_decode
// one-byte escape decode: next scan state and up to two result words
// ----------------------------------------------------------------------------
module sqlu_decode (
  input  sqlu_pkg::scan_t st,
  input  logic [7:0]      byte_in,
  input  logic            last,
  output sqlu_pkg::scan_t st_next,
  output sqlu_pkg::push_t push
);
  import sqlu_pkg::*;

  function automatic push_t emit(push_t p, logic [7:0] b);
    push_t q;
    q = p;
    if (p.n == 2'd0) begin
      q.r0 = '{data: b, has: 1'b1, last: 1'b0};
    end else begin
      q.r1 = '{data: b, has: 1'b1, last: 1'b0};
    end
    q.n = p.n + 2'd1;
    return q;
  endfunction

  logic       is_oct;
  logic       fresh;
  logic [7:0] acc_shift;
  logic [1:0] dig_inc;
  scan_t      nx;
  push_t      p;

  assign is_oct    = (byte_in >= CH_ZERO) && (byte_in <= CH_SEVEN);
  assign acc_shift = {st.acc[4:0], byte_in[2:0]};
  assign dig_inc   = st.dig + 2'd1;

  always_comb begin
    nx    = st;
    p     = '0;
    fresh = 1'b1;

    // octal run continues or is flushed
    if (st.mode == MODE_OCTAL) begin
      if (is_oct) begin
        nx.acc = acc_shift;
        nx.dig = dig_inc;
        if (dig_inc == OCT_MAX_DIGITS || dig_inc == 2'd0) begin
          p  = emit(p, acc_shift);
          nx = SCAN_RESET;
        end
        fresh = 1'b0;
      end else begin
        p  = emit(p, st.acc);
        nx = SCAN_RESET;
      end
    end

    if (fresh) begin
      unique case (nx.mode)
        MODE_QUOTE: begin
          p       = emit(p, byte_in);
          nx.mode = MODE_NORMAL;
        end
        MODE_BSLASH: begin
          nx.mode = MODE_NORMAL;
          if (is_oct) begin
            nx.acc  = {5'd0, byte_in[2:0]};
            nx.dig  = 2'd1;
            nx.mode = MODE_OCTAL;
          end else begin
            case (byte_in)
              CH_B:    p = emit(p, CODE_BS);
              CH_F:    p = emit(p, CODE_FF);
              CH_N:    p = emit(p, CODE_LF);
              CH_R:    p = emit(p, CODE_CR);
              CH_T:    p = emit(p, CODE_TAB);
              default: p = emit(p, byte_in);
            endcase
          end
        end
        default: begin
          if (byte_in == CH_QUOTE) begin
            nx.mode = MODE_QUOTE;
          end else if (byte_in == CH_BSLASH) begin
            nx.mode = MODE_BSLASH;
          end else begin
            p = emit(p, byte_in);
          end
        end
      endcase
    end

    // end of string: flush, mark last, return to reset state
    if (last) begin
      if (nx.mode == MODE_OCTAL && p.n < 2'd2) begin
        p = emit(p, nx.acc);
      end
      if (p.n == 2'd0) begin
        p.n  = 2'd1;
        p.r0 = '{data: 8'h00, has: 1'b0, last: 1'b1};
      end else if (p.n == 2'd1) begin
        p.r0.last = 1'b1;
      end else begin
        p.r1.last = 1'b1;
      end
      nx = SCAN_RESET;
    end
  end

  assign st_next = nx;
  assign push    = p;

endmodule

// File: hdl/sqlu_outq.sv
// ----------------------------------------------------------------------------
// sqlu_outq
// small result queue, takes up to two words per cycle, gives one
// ----------------------------------------------------------------------------
module sqlu_outq (
  input  logic             clk,
  input  logic             rst,
  input  sqlu_pkg::push_t  push,
  input  logic             pop,
  output sqlu_pkg::res_t   head,
  output sqlu_pkg::qstat_t stat
);
  import sqlu_pkg::*;

  res_t              q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic [QCNT_W-1:0] count_next;
  logic              do_pop;

  assign do_pop     = pop && (count != '0);
  assign count_next = count + QCNT_W'(push.n) - QCNT_W'(do_pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_W'(push.n);
      rd_ptr <= rd_ptr + QPTR_W'(do_pop);
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      q[wr_ptr] <= push.r0;
    end
    if (push.n == 2'd2) begin
      q[wr_ptr + QPTR_W'(1)] <= push.r1;
    end
  end

  assign head       = q[rd_ptr];
  assign stat.valid = (count != '0);
  assign stat.room  = (count <= QCNT_W'(QDEPTH - 2));
  assign stat.count = count;

endmodule
